/* hdl/sfpl_pkg.sv */
`timescale 1ns / 1ps

package sfpl_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int FRAC        = SAMPLE_BITS - 2;
  localparam int STATE_BITS  = 40;
  localparam int COEF_BITS   = 32;
  localparam int CFG_BITS    = SAMPLE_BITS - 1;
  localparam int EXP_DEPTH   = 256;
  localparam int IDX_BITS    = $clog2(EXP_DEPTH);
  localparam int EXP_BITS    = 24;
  localparam int IFRAC_BITS  = 16;
  localparam int MUL_BITS    = 32;
  localparam int PROD_BITS   = 2 * MUL_BITS;
  localparam int REG_IDX_BITS = 3;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_INPUT_GAIN = 3'd0,
    REG_RETURN1    = 3'd1,
    REG_RETURN2    = 3'd2,
    REG_LEAK       = 3'd3,
    REG_TRACK1     = 3'd4,
    REG_TRACK2     = 3'd5,
    REG_THRESHOLD  = 3'd6,
    REG_DRIVE      = 3'd7
  } cfg_reg_t;

  typedef logic [EXP_BITS-1:0] exp_tab_t [EXP_DEPTH];

  localparam longint unsigned ONE_Q31 = 64'd1 << 31;

  // shift and subtract, evaluated only while the table is built
  function automatic longint unsigned div_small(longint unsigned x, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 64'd0;
    r = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], x[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic longint unsigned exp_neg_q31(longint unsigned f);
    longint unsigned term;
    longint          sum;
    term = ONE_Q31;
    sum  = longint'(ONE_Q31);
    for (int n = 1; n <= 24; n++) begin
      term = div_small((term * f) >> 31, 64'(n));
      if (n % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    return (sum < 0) ? 64'd0 : longint'(sum);
  endfunction

  function automatic exp_tab_t build_exp_table();
    exp_tab_t        tab;
    longint unsigned e1;
    longint unsigned num;
    longint unsigned whole;
    longint unsigned f;
    longint unsigned v;
    e1 = exp_neg_q31(ONE_Q31);
    for (int i = 0; i < EXP_DEPTH; i++) begin
      num   = 64'd20 * longint'(i);
      whole = num / EXP_DEPTH;
      f     = ((num % EXP_DEPTH) << 31) / EXP_DEPTH;
      v     = exp_neg_q31(f);
      for (longint unsigned k = 0; k < whole; k++) begin
        v = (v * e1) >> 31;
      end
      v = (v + 64'd128) >> 8;
      if (v > (64'd1 << 23)) begin
        v = 64'd1 << 23;
      end
      tab[i] = v[EXP_BITS-1:0];
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TABLE = build_exp_table();

endpackage

/* hdl/sfpl_mul.sv */
`timescale 1ns / 1ps

module sfpl_mul (
  input  logic                               clk,
  input  logic [sfpl_pkg::MUL_BITS-1:0]      mul_a,
  input  logic [sfpl_pkg::MUL_BITS-1:0]      mul_b,
  output logic [sfpl_pkg::PROD_BITS-1:0]     prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= {{sfpl_pkg::MUL_BITS{1'b0}}, mul_a} * {{sfpl_pkg::MUL_BITS{1'b0}}, mul_b};
  end

endmodule

/* hdl/stereo_feedback_peak_limiter.sv */
`timescale 1ns / 1ps

// channel  ports                                            handshake
// in       in_left_in, in_right_in, in_block_end_in         in_valid / in_ready
// out      out_left_out, out_right_out, out_block_end_out   out_valid / out_ready
// cfg      cfg_we, cfg_index, cfg_data                      write on cfg_we
//
// Each accepted word runs through five steps for table interpolation, gain and
// both channels, three per envelope term, and one to load the output; a new word
// is accepted only in idle, after the previous word has left the done step.
// All products go through one registered 32x32 multiplier.
// Synchronous active-low reset clears the sequencer and envelope state and
// loads register defaults.
// A stalled output holds the finished word; the next word may enter meanwhile.

module stereo_feedback_peak_limiter (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic signed [sfpl_pkg::SAMPLE_BITS-1:0]   in_left_in,
  input  logic signed [sfpl_pkg::SAMPLE_BITS-1:0]   in_right_in,
  input  logic                                      in_block_end_in,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic signed [sfpl_pkg::SAMPLE_BITS-1:0]   out_left_out,
  output logic signed [sfpl_pkg::SAMPLE_BITS-1:0]   out_right_out,
  output logic                                      out_block_end_out,
  input  logic                                      cfg_we,
  input  logic [sfpl_pkg::REG_IDX_BITS-1:0]         cfg_index,
  input  logic [sfpl_pkg::COEF_BITS-1:0]            cfg_data
);

  localparam int SB  = sfpl_pkg::SAMPLE_BITS;
  localparam int STB = sfpl_pkg::STATE_BITS;
  localparam int MB  = sfpl_pkg::MUL_BITS;
  localparam int EB  = sfpl_pkg::EXP_BITS;
  localparam int RB  = SB + 2;
  localparam int WB  = STB + 4;
  localparam int SH  = 38 - sfpl_pkg::FRAC;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_TAB   = 10'b0000000010,
    S_EXP   = 10'b0000000100,
    S_GAIN  = 10'b0000001000,
    S_LEFT  = 10'b0000010000,
    S_RIGHT = 10'b0000100000,
    S_TLO   = 10'b0001000000,
    S_THI   = 10'b0010000000,
    S_TADD  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [sfpl_pkg::COEF_BITS-1:0] igc_r, ret1_r, ret2_r, leak_r, trk1_r, trk2_r;
  logic [sfpl_pkg::CFG_BITS-1:0]  thr_r, drv_r;
  logic [STB-1:0] env_r, s1_r, s2_r;

  logic signed [SB-1:0] inl_r, inr_r;
  logic                 be_r;
  logic [EB-1:0]        cur_r;
  logic                 up_r;
  logic [SB-1:0]        g_r;
  logic signed [SB-1:0] l_r, r_r;
  logic [STB-1:0]       vin_r;
  logic signed [WB-1:0] delta_r;
  logic [2:0]           term_r;
  logic [MB-1:0]        tlo_r;

  logic signed [SB-1:0] out_l_r, out_r_r;
  logic                 out_be_r, out_valid_r;

  logic [MB-1:0]                       mul_a, mul_b;
  logic [sfpl_pkg::PROD_BITS-1:0]      prod_r;

  sfpl_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  function automatic logic signed [SB-1:0] sat_out(logic [RB-1:0] m, logic neg);
    logic [RB-1:0] lim;
    lim = RB'(1) << (SB - 1);
    if (neg) begin
      return (m > lim) ? -(SB'(1) << (SB - 1)) : -SB'(m);
    end
    return (m > lim - RB'(1)) ? SB'(lim - RB'(1)) : SB'(m);
  endfunction

  function automatic logic [SB-1:0] mag(logic signed [SB-1:0] s);
    return s[SB-1] ? (~s + SB'(1)) : s;
  endfunction

  function automatic logic [STB-1:0] clamp_state(logic signed [WB-1:0] v);
    if (v < 0) begin
      return '0;
    end
    if (v > $signed({{(WB-STB){1'b0}}, {STB{1'b1}}})) begin
      return {STB{1'b1}};
    end
    return v[STB-1:0];
  endfunction

  // table lookup
  logic [sfpl_pkg::IDX_BITS-1:0]   idx;
  logic [sfpl_pkg::IFRAC_BITS-1:0] ifrac;
  logic [EB-1:0]                   cur, nxt, tdiff;
  assign idx   = env_r[STB-1 -: sfpl_pkg::IDX_BITS];
  assign ifrac = env_r[STB-1-sfpl_pkg::IDX_BITS -: sfpl_pkg::IFRAC_BITS];
  assign cur   = sfpl_pkg::EXP_TABLE[idx];
  assign nxt   = (idx == {sfpl_pkg::IDX_BITS{1'b1}}) ? cur :
                 sfpl_pkg::EXP_TABLE[idx + sfpl_pkg::IDX_BITS'(1)];
  assign tdiff = (nxt <= cur) ? (cur - nxt) : (nxt - cur);

  logic [EB-1:0] e_val;
  logic [SB-1:0] g_val;
  logic [RB-1:0] rnd;
  logic signed [SB-1:0] ch_val;
  logic [SB-1:0] amp;
  logic signed [STB+1:0] vin_s;
  assign e_val  = up_r ? (cur_r + EB'(prod_r >> 16)) : (cur_r - EB'(prod_r >> 16));
  assign g_val  = SB'((prod_r + (64'd1 << 22)) >> 23);
  assign rnd    = RB'((prod_r + (64'd1 << (sfpl_pkg::FRAC - 1))) >> sfpl_pkg::FRAC);
  assign ch_val = sat_out(rnd, (state_r == S_LEFT) ? inl_r[SB-1] : inr_r[SB-1]);
  assign amp    = (mag(l_r) > mag(ch_val)) ? mag(l_r) : mag(ch_val);
  assign vin_s  = $signed({2'b00, (STB'(amp) << SH)}) - $signed({2'b00, (STB'(thr_r) << SH)})
                - $signed({2'b00, env_r});

  // envelope terms
  logic [STB-1:0]        tx;
  logic [MB-1:0]         tc;
  logic signed [STB+1:0] d1, d2;
  logic [STB-1:0]        m1, m2;
  logic signed [WB-1:0]  tval;
  assign d1 = $signed({2'b00, env_r}) - $signed({2'b00, s1_r});
  assign d2 = $signed({2'b00, env_r}) - $signed({2'b00, s2_r});
  assign m1 = d1[STB+1] ? STB'(-d1) : STB'(d1);
  assign m2 = d2[STB+1] ? STB'(-d2) : STB'(d2);
  assign tval = $signed(WB'(tlo_r)) + $signed(WB'(prod_r[STB:0]));

  always_comb begin
    unique case (term_r)
      3'd0:    begin tx = vin_r; tc = igc_r;  end
      3'd1:    begin tx = s1_r;  tc = ret1_r; end
      3'd2:    begin tx = s2_r;  tc = ret2_r; end
      3'd3:    begin tx = env_r; tc = leak_r; end
      3'd4:    begin tx = m1;    tc = trk1_r; end
      3'd5:    begin tx = m2;    tc = trk2_r; end
      default: begin tx = '0;    tc = '0;     end
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_TAB:   begin mul_a = MB'(tdiff);       mul_b = MB'(ifrac); end
      S_EXP:   begin mul_a = MB'(e_val);       mul_b = MB'(drv_r); end
      S_GAIN:  begin mul_a = MB'(mag(inl_r));  mul_b = MB'(g_val); end
      S_LEFT:  begin mul_a = MB'(mag(inr_r));  mul_b = MB'(g_r);   end
      S_TLO:   begin mul_a = tx[MB-1:0];       mul_b = tc;         end
      S_THI:   begin mul_a = MB'(tx[STB-1:MB]); mul_b = tc;        end
      default: begin mul_a = '0;               mul_b = '0;         end
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_TAB;
      S_TAB:   state_nxt = S_EXP;
      S_EXP:   state_nxt = S_GAIN;
      S_GAIN:  state_nxt = S_LEFT;
      S_LEFT:  state_nxt = S_RIGHT;
      S_RIGHT: state_nxt = S_TLO;
      S_TLO:   state_nxt = S_THI;
      S_THI:   state_nxt = S_TADD;
      S_TADD:  state_nxt = (term_r == 3'd5) ? S_DONE : S_TLO;
      S_DONE:  if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      env_r       <= '0;
      s1_r        <= '0;
      s2_r        <= '0;
      term_r      <= '0;
      igc_r       <= 32'd97391389;
      ret1_r      <= 32'd973914;
      ret2_r      <= 32'd973914;
      leak_r      <= 32'd2390449;
      trk1_r      <= 32'd121740;
      trk2_r      <= 32'd48696;
      thr_r       <= sfpl_pkg::CFG_BITS'(1) << (sfpl_pkg::FRAC - 1);
      drv_r       <= sfpl_pkg::CFG_BITS'(4242871);
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (sfpl_pkg::cfg_reg_t'(cfg_index))
          sfpl_pkg::REG_INPUT_GAIN: igc_r  <= cfg_data;
          sfpl_pkg::REG_RETURN1:    ret1_r <= cfg_data;
          sfpl_pkg::REG_RETURN2:    ret2_r <= cfg_data;
          sfpl_pkg::REG_LEAK:       leak_r <= cfg_data;
          sfpl_pkg::REG_TRACK1:     trk1_r <= cfg_data;
          sfpl_pkg::REG_TRACK2:     trk2_r <= cfg_data;
          sfpl_pkg::REG_THRESHOLD:  thr_r  <= cfg_data[sfpl_pkg::CFG_BITS-1:0];
          sfpl_pkg::REG_DRIVE:      drv_r  <= cfg_data[sfpl_pkg::CFG_BITS-1:0];
          default: ;
        endcase
      end
      if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_RIGHT) begin
        term_r <= '0;
      end
      if (state_r == S_TADD) begin
        term_r <= term_r + 3'd1;
        unique case (term_r)
          3'd3:    env_r <= clamp_state($signed(WB'(env_r)) + delta_r - tval);
          3'd4:    s1_r  <= clamp_state(d1[STB+1] ? $signed(WB'(s1_r)) - tval
                                                  : $signed(WB'(s1_r)) + tval);
          3'd5:    s2_r  <= clamp_state(d2[STB+1] ? $signed(WB'(s2_r)) - tval
                                                  : $signed(WB'(s2_r)) + tval);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      inl_r <= in_left_in;
      inr_r <= in_right_in;
      be_r  <= in_block_end_in;
    end
    if (state_r == S_TAB) begin
      cur_r <= cur;
      up_r  <= (nxt > cur);
    end
    if (state_r == S_GAIN) begin
      g_r <= g_val;
    end
    if (state_r == S_LEFT) begin
      l_r <= ch_val;
    end
    if (state_r == S_RIGHT) begin
      r_r     <= ch_val;
      vin_r   <= (vin_s < 0) ? '0 : vin_s[STB-1:0];
      delta_r <= '0;
    end
    if (state_r == S_THI) begin
      tlo_r <= prod_r[sfpl_pkg::PROD_BITS-1:MB];
    end
    if (state_r == S_TADD && term_r < 3'd3) begin
      delta_r <= delta_r + tval;
    end
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_l_r  <= l_r;
      out_r_r  <= r_r;
      out_be_r <= be_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_left_out      = out_l_r;
  assign out_right_out     = out_r_r;
  assign out_block_end_out = out_be_r;

endmodule

/* tb/sv/sfpl_checker.sv */
`timescale 1ns / 1ps

module sfpl_checker (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  input  logic                                    in_ready,
  input  logic signed [sfpl_pkg::SAMPLE_BITS-1:0] in_left_in,
  input  logic signed [sfpl_pkg::SAMPLE_BITS-1:0] in_right_in,
  input  logic                                    in_block_end_in,
  input  logic                                    out_valid,
  input  logic                                    out_ready,
  input  logic signed [sfpl_pkg::SAMPLE_BITS-1:0] out_left_out,
  input  logic signed [sfpl_pkg::SAMPLE_BITS-1:0] out_right_out,
  input  logic                                    out_block_end_out,
  input  logic                                    cfg_we,
  input  logic [sfpl_pkg::REG_IDX_BITS-1:0]       cfg_index,
  input  logic [sfpl_pkg::COEF_BITS-1:0]          cfg_data,
  output int                                      fail_count,
  output int                                      words_pending,
  output int                                      words_checked
);

  localparam int SAMPLE_BITS = sfpl_pkg::SAMPLE_BITS;
  localparam int FRAC        = sfpl_pkg::FRAC;
  localparam int EXP_DEPTH   = sfpl_pkg::EXP_DEPTH;
  localparam int CFG_BITS    = sfpl_pkg::CFG_BITS;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
    logic                          block_end;
  } limited_word_t;

  localparam longint unsigned ONE_31 = 64'd1 << 31;
  localparam longint          ENV_MAX = (64'sd1 <<< 40) - 1;

  limited_word_t    expected_words[$];
  logic [23:0]      gain_curve [EXP_DEPTH];
  logic [31:0]      k_input, k_ret1, k_ret2, k_leak, k_trk1, k_trk2;
  longint unsigned  thr, drv;
  longint           env, node1, node2;

  function automatic longint unsigned neg_exp_series(longint unsigned f);
    longint unsigned t;
    longint          acc;
    t = ONE_31;
    acc = longint'(ONE_31);
    for (int n = 1; n <= 24; n++) begin
      t = ((t * f) >> 31) / longint'(n);
      if (n % 2 == 1) acc = acc - longint'(t);
      else acc = acc + longint'(t);
    end
    return (acc < 0) ? 64'd0 : longint'(acc);
  endfunction

  function automatic void load_gain_curve();
    longint unsigned e1, num, whole, f, v;
    e1 = neg_exp_series(ONE_31);
    for (int i = 0; i < EXP_DEPTH; i++) begin
      num = 64'd20 * longint'(i);
      whole = num / EXP_DEPTH;
      f = ((num % EXP_DEPTH) << 31) / EXP_DEPTH;
      v = neg_exp_series(f);
      for (longint unsigned k = 0; k < whole; k++) v = (v * e1) >> 31;
      v = (v + 64'd128) >> 8;
      if (v > (64'd1 << 23)) v = 64'd1 << 23;
      gain_curve[i] = v[23:0];
    end
  endfunction

  function automatic longint frac_mul(longint unsigned x, logic [31:0] c);
    longint unsigned cu;
    cu = {32'd0, c};
    return longint'(((x >> 32) & 64'hFF) * cu + (((x & 64'hFFFF_FFFF) * cu) >> 32));
  endfunction

  function automatic longint signed_frac_mul(longint d, logic [31:0] c);
    if (d < 0) return -frac_mul(longint'(-d), c);
    return frac_mul(longint'(d), c);
  endfunction

  function automatic longint clamp_env(longint v);
    if (v < 0) return 0;
    if (v > ENV_MAX) return ENV_MAX;
    return v;
  endfunction

  function automatic longint scale_sample(longint s, longint unsigned g);
    longint unsigned mag, rr;
    mag = (s < 0) ? longint'(-s) : longint'(s);
    rr = (mag * g + (64'd1 << (FRAC - 1))) >> FRAC;
    if (s < 0) return (rr > (64'd1 << (SAMPLE_BITS - 1))) ? -(64'sd1 <<< (SAMPLE_BITS - 1))
                                                           : -longint'(rr);
    return (rr > ((64'd1 << (SAMPLE_BITS - 1)) - 1)) ? (64'sd1 <<< (SAMPLE_BITS - 1)) - 1
                                                      : longint'(rr);
  endfunction

  function automatic limited_word_t limit_word(longint l_in, longint r_in, logic be);
    longint unsigned p, idx, fr, cur, nxt, e, g, al, ar, amp;
    longint          lo, ro, vin, delta, env_next;
    limited_word_t   w;
    p = longint'(env) * EXP_DEPTH;
    idx = p >> 40;
    fr = (p >> 24) & 64'hFFFF;
    if (idx >= EXP_DEPTH) idx = EXP_DEPTH - 1;
    cur = gain_curve[idx];
    nxt = (idx + 1 < EXP_DEPTH) ? gain_curve[idx + 1] : cur;
    if (nxt <= cur) e = cur - (((cur - nxt) * fr) >> 16);
    else e = cur + (((nxt - cur) * fr) >> 16);
    g = (e * drv + (64'd1 << 22)) >> 23;
    lo = scale_sample(l_in, g);
    ro = scale_sample(r_in, g);
    al = (lo < 0) ? longint'(-lo) : longint'(lo);
    ar = (ro < 0) ? longint'(-ro) : longint'(ro);
    amp = (al > ar) ? al : ar;
    vin = longint'(amp << (38 - FRAC)) - longint'(thr << (38 - FRAC)) - env;
    vin = clamp_env(vin);
    delta = frac_mul(vin, k_input) + frac_mul(node1, k_ret1) + frac_mul(node2, k_ret2)
          - frac_mul(env, k_leak);
    env_next = clamp_env(env + delta);
    env = env_next;
    node1 = clamp_env(node1 + signed_frac_mul(env_next - node1, k_trk1));
    node2 = clamp_env(node2 + signed_frac_mul(env_next - node2, k_trk2));
    w.left = lo[SAMPLE_BITS-1:0];
    w.right = ro[SAMPLE_BITS-1:0];
    w.block_end = be;
    return w;
  endfunction

  initial begin
    load_gain_curve();
  end

  assign words_pending = expected_words.size();

  always @(posedge clk) begin
    limited_word_t want;
    if (!rst_n) begin
      expected_words.delete();
      fail_count = 0;
      words_checked = 0;
      k_input <= 32'd97391389;
      k_ret1 <= 32'd973914;
      k_ret2 <= 32'd973914;
      k_leak <= 32'd2390449;
      k_trk1 <= 32'd121740;
      k_trk2 <= 32'd48696;
      thr <= 64'd1 << (FRAC - 1);
      drv <= 64'd4242871;
      env = 0;
      node1 = 0;
      node2 = 0;
    end else begin
      if (cfg_we) begin
        case (sfpl_pkg::cfg_reg_t'(cfg_index))
          sfpl_pkg::REG_INPUT_GAIN: k_input <= cfg_data;
          sfpl_pkg::REG_RETURN1:    k_ret1 <= cfg_data;
          sfpl_pkg::REG_RETURN2:    k_ret2 <= cfg_data;
          sfpl_pkg::REG_LEAK:       k_leak <= cfg_data;
          sfpl_pkg::REG_TRACK1:     k_trk1 <= cfg_data;
          sfpl_pkg::REG_TRACK2:     k_trk2 <= cfg_data;
          sfpl_pkg::REG_THRESHOLD:  thr <= {41'd0, cfg_data[CFG_BITS-1:0]};
          sfpl_pkg::REG_DRIVE:      drv <= {41'd0, cfg_data[CFG_BITS-1:0]};
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        words_checked++;
        if (expected_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected word L=%0d R=%0d E=%0b", $realtime,
                     out_left_out, out_right_out, out_block_end_out);
        end else begin
          want = expected_words.pop_front();
          if (want.left !== out_left_out || want.right !== out_right_out ||
              want.block_end !== out_block_end_out) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch exp L=%0d R=%0d E=%0b got L=%0d R=%0d E=%0b",
                       $realtime, want.left, want.right, want.block_end,
                       out_left_out, out_right_out, out_block_end_out);
          end
        end
      end
      if (in_valid && in_ready)
        expected_words.push_back(limit_word(in_left_in, in_right_in, in_block_end_in));
    end
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam int SAMPLE_BITS  = sfpl_pkg::SAMPLE_BITS;
  localparam int REG_IDX_BITS = sfpl_pkg::REG_IDX_BITS;
  localparam int COEF_BITS    = sfpl_pkg::COEF_BITS;
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE = 40;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [SAMPLE_BITS-1:0] in_left_in = '0;
  logic signed [SAMPLE_BITS-1:0] in_right_in = '0;
  logic                          in_block_end_in = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_left_out;
  logic signed [SAMPLE_BITS-1:0] out_right_out;
  logic                          out_block_end_out;
  logic                          cfg_we = 1'b0;
  logic [REG_IDX_BITS-1:0]       cfg_index = '0;
  logic [COEF_BITS-1:0]          cfg_data = '0;
  logic                          hold_req = 1'b0;
  logic                          rx_gaps = 1'b1;
  logic                          tx_gaps = 1'b1;
  int                            fail_count, words_pending, words_checked;
  int                            idle_cycles = 0;
  int                            settings_run = 0;

  always #5 clk = ~clk;

  stereo_feedback_peak_limiter dut (.*);

  sfpl_checker chk (.*);

  always @(posedge clk) begin
    int hold_left;
    if (hold_req) hold_left = 300;
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (rx_gaps && $urandom_range(0, 99) < 4) begin
      out_ready <= 1'b0;
      hold_left = $urandom_range(10, 60);
    end else begin
      out_ready <= !rx_gaps || ($urandom_range(0, 99) < 75);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout with %0d words outstanding", words_pending);
      $display("tb failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    if (!tx_gaps) return 0;
    if ($urandom_range(0, 99) < 3) return $urandom_range(20, 80);
    if ($urandom_range(0, 99) < 40) return $urandom_range(1, 4);
    return 0;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      1: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      2: return SAMPLE_BITS'($signed($urandom_range(0, 2000)) - 1000);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  task automatic send_word(logic [SAMPLE_BITS-1:0] l, logic [SAMPLE_BITS-1:0] r, logic be);
    int gap;
    in_valid <= 1'b1;
    in_left_in <= l;
    in_right_in <= r;
    in_block_end_in <= be;
    do @(posedge clk); while (!in_ready);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(sfpl_pkg::cfg_reg_t idx, logic [COEF_BITS-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic load_settings(logic [31:0] kin, logic [31:0] r1, logic [31:0] r2,
                               logic [31:0] lk, logic [31:0] t1, logic [31:0] t2,
                               logic [31:0] th, logic [31:0] dr);
    drain();
    write_reg(sfpl_pkg::REG_INPUT_GAIN, kin);
    write_reg(sfpl_pkg::REG_RETURN1, r1);
    write_reg(sfpl_pkg::REG_RETURN2, r2);
    write_reg(sfpl_pkg::REG_LEAK, lk);
    write_reg(sfpl_pkg::REG_TRACK1, t1);
    write_reg(sfpl_pkg::REG_TRACK2, t2);
    write_reg(sfpl_pkg::REG_THRESHOLD, th);
    write_reg(sfpl_pkg::REG_DRIVE, dr);
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  task automatic random_words(int n);
    for (int i = 0; i < n; i++)
      send_word(pick_sample(), pick_sample(), 1'($urandom_range(0, 7) == 0));
  endtask

  localparam logic [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word('0, '0, 1'b0);
    send_word(S_MAX, S_MAX, 1'b1);
    send_word(S_MIN, S_MIN, 1'b0);
    send_word(S_MAX, S_MIN, 1'b1);
    send_word(S_MIN, S_MAX, 1'b0);
    send_word('1, 24'd1, 1'b0);
    send_word(24'h555555, 24'hAAAAAA, 1'b1);
    send_word(24'hAAAAAA, 24'h555555, 1'b0);
    random_words(60);

    // saturate the envelope network to reach the top of the gain table
    load_settings('1, '1, '1, '0, '1, '1, 32'hFF80_0000, 32'h007F_FFFF);
    for (int i = 0; i < 12; i++) send_word(S_MAX, S_MIN, i[0]);
    random_words(70);

    load_settings('0, '0, '0, '0, '0, '0, '1, '0);
    send_word(S_MAX, S_MIN, 1'b1);
    random_words(40);

    load_settings('0, '0, '0, '1, '1, '1, 32'd0, 32'hFFFF_FFFF);
    random_words(50);

    load_settings($urandom, $urandom_range(0, 1 << 24), $urandom_range(0, 1 << 24),
                  $urandom_range(0, 1 << 26), $urandom_range(0, 1 << 20),
                  $urandom_range(0, 1 << 20), $urandom, $urandom);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    random_words(60);

    load_settings(32'd97391389, 32'd973914, 32'd973914, 32'd2390449, 32'd121740,
                  32'd48696, 32'd2097152, 32'd4242871);
    rx_gaps <= 1'b0;
    tx_gaps <= 1'b0;
    random_words(40);
    rx_gaps <= 1'b1;
    tx_gaps <= 1'b1;
    random_words(60);

    drain();
    $display("%0d words checked across %0d register settings plus reset values",
             words_checked, settings_run);
    if (fail_count == 0 && words_pending == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
